// ===== src/indexed_service_queue_unit_defines.svh =====
// assertion macros for the service queue unit
`ifndef INDEXED_SERVICE_QUEUE_UNIT_DEFINES_SVH
`define INDEXED_SERVICE_QUEUE_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define ISQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ISQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isq_pkg.sv =====
package isq_pkg;

  localparam logic [1:0] OP_GIVE  = 2'd0;
  localparam logic [1:0] OP_SEAT  = 2'd1;
  localparam logic [1:0] OP_KICK  = 2'd2;
  localparam logic [1:0] OP_BRIBE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] buzzer_id;
  } isq_in_t;

  typedef struct packed {
    logic [7:0] out_id;
    logic [1:0] status;
    logic [8:0] length_now;
  } isq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIX,
    S_FIX2,
    S_DONE
  } isq_state_t;

endpackage

// ===== src/isq_link_ram.sv =====
module isq_link_ram import isq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/indexed_service_queue_unit.sv =====
// channel | direction | payload   | handshake
// in      | input     | isq_in_t  | in_valid / in_stall
// out     | output    | isq_out_t | out_valid / out_stall
//
// an item that links or unlinks an id issues its link and flag reads at accept, latches them
// in S_READ and rewrites the links in S_FIX, S_FIX2 and S_DONE; a move of the front id skips
// S_FIX2, and a rejected item goes from S_READ straight to S_DONE
// after S_DONE the result waits as pending and is then loaded into the out_data register
// one item is in flight at a time; a result waiting behind a stalled one holds off the input
// rst is synchronous; queued flags live in a ram and are only trusted below issued_count,
// so no table needs a clearing pass
module indexed_service_queue_unit import isq_pkg::*; #(
  parameter int ID_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  isq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output isq_out_t out_data
);

  localparam int AW = $clog2(ID_COUNT);
  localparam int PW = AW + 1;           // id width with room for the null marker
  localparam logic [PW-1:0] NIL = PW'(ID_COUNT);

  // control registers
  isq_state_t state, state_next;
  logic [PW-1:0] head_id, tail_id, free_top, issued_count, entry_count;
  // item registers
  logic [1:0]    op;
  logic [PW-1:0] cur;           // id being worked on
  logic [1:0]    res_status;
  logic          res_pending;   // result computed, waiting for output register

  // link rams and queued flag ram
  logic          n_we, p_we, f_we;
  logic [AW-1:0] n_wa, p_wa, f_wa, rd_a;
  logic [PW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic [0:0]    f_wd, f_rd;

  isq_link_ram #(.DEPTH(ID_COUNT), .WIDTH(PW)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd)
  );
  isq_link_ram #(.DEPTH(ID_COUNT), .WIDTH(PW)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd)
  );
  isq_link_ram #(.DEPTH(ID_COUNT), .WIDTH(1)) u_flag (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(rd_a), .rdata(f_rd)
  );

  // links of cur, held from the read cycle
  logic [PW-1:0] lp, ln;

  logic accept_in;
  assign in_stall  = (state != S_IDLE) || res_pending;
  assign accept_in = in_valid && !in_stall;

  logic in_range;
  assign in_range = ({1'b0, in_data.buzzer_id} < 9'(ID_COUNT)) || (ID_COUNT > 256);

  // id and first status of the offered item
  logic [PW-1:0] cur_in;
  logic [1:0]    st_in;

  always_comb begin
    cur_in = '0;
    st_in  = ST_OK;
    case (in_data.operation)
      OP_GIVE: begin
        if (free_top != NIL) cur_in = free_top;
        else if (issued_count != NIL) cur_in = issued_count;
        else st_in = ST_FULL;
      end
      OP_SEAT: begin
        cur_in = head_id;
        if (head_id == NIL) st_in = ST_ABSENT;
      end
      default: begin
        cur_in = PW'(in_data.buzzer_id);
        // ids never handed out are not queued
        if (!in_range || (PW'(in_data.buzzer_id) >= issued_count)) st_in = ST_ABSENT;
      end
    endcase
  end

  // reads are issued with the incoming id, data is there in S_READ
  // no write happens in S_IDLE, so the read never races a write
  assign rd_a = cur_in[AW-1:0];

  // status once the queued flag of a named id is known
  logic [1:0] st_read;
  assign st_read = ((op == OP_KICK || op == OP_BRIBE) && res_status == ST_OK && !f_rd[0])
                   ? ST_ABSENT : res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
    n_wa = cur[AW-1:0]; p_wa = cur[AW-1:0]; f_wa = cur[AW-1:0];
    n_wd = NIL; p_wd = NIL; f_wd = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept_in) state_next = S_READ;
      end
      S_READ: begin
        state_next = (st_read == ST_OK) ? S_FIX : S_DONE;
      end
      S_FIX: begin
        state_next = S_DONE;
        case (op)
          OP_GIVE: begin
            // cur.prev = tail, tail.next = cur, mark queued
            p_we = 1'b1; p_wd = tail_id;
            n_we = (tail_id != NIL); n_wa = tail_id[AW-1:0]; n_wd = cur;
            f_we = 1'b1; f_wd = 1'b1;
            state_next = S_FIX2;
          end
          OP_SEAT, OP_KICK: begin
            // prev.next = n ; next.prev = p ; clear queued
            n_we = (lp != NIL); n_wa = lp[AW-1:0]; n_wd = ln;
            p_we = (ln != NIL); p_wa = ln[AW-1:0]; p_wd = lp;
            f_we = 1'b1; f_wd = 1'b0;
            state_next = S_FIX2;
          end
          OP_BRIBE: begin
            if (head_id != cur) begin
              n_we = (lp != NIL); n_wa = lp[AW-1:0]; n_wd = ln;
              p_we = (ln != NIL); p_wa = ln[AW-1:0]; p_wd = lp;
              state_next = S_FIX2;
            end
          end
          default: ;
        endcase
      end
      S_FIX2: begin
        state_next = S_DONE;
        case (op)
          OP_GIVE: begin
            n_we = 1'b1; n_wd = NIL;
          end
          OP_SEAT, OP_KICK: begin
            n_we = 1'b1; n_wd = free_top;
          end
          OP_BRIBE: begin
            // cur.next = head, head.prev = cur
            n_we = 1'b1; n_wd = head_id;
            p_we = 1'b1; p_wa = head_id[AW-1:0]; p_wd = cur;
          end
          default: ;
        endcase
      end
      S_DONE: begin
        state_next = S_IDLE;
        // new front has no predecessor; harmless when it already was the front
        if (op == OP_BRIBE && res_status == ST_OK) begin
          p_we = 1'b1; p_wd = NIL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_id <= NIL; tail_id <= NIL; free_top <= NIL;
      issued_count <= '0; entry_count <= '0;
      res_pending <= 1'b0;
      op <= OP_GIVE; res_status <= ST_OK; cur <= '0;
      lp <= NIL; ln <= NIL;
    end else begin
      if (accept_in) begin
        op <= in_data.operation;
        cur <= cur_in;
        res_status <= st_in;
      end
      if (state == S_READ) begin
        lp <= p_rd; ln <= n_rd;
        res_status <= st_read;
        if (op == OP_GIVE && res_status == ST_OK) begin
          if (free_top != NIL) free_top <= n_rd;
          else issued_count <= issued_count + 1'b1;
        end
      end
      if (state == S_FIX) begin
        case (op)
          OP_GIVE: begin
            if (tail_id == NIL) head_id <= cur;
            tail_id <= cur;
            entry_count <= entry_count + 1'b1;
          end
          OP_SEAT, OP_KICK: begin
            if (lp == NIL) head_id <= ln;
            if (ln == NIL) tail_id <= lp;
            entry_count <= entry_count - 1'b1;
          end
          OP_BRIBE: begin
            if (head_id != cur) begin
              if (ln == NIL) tail_id <= lp;
            end
          end
          default: ;
        endcase
      end
      if (state == S_FIX2) begin
        case (op)
          OP_SEAT, OP_KICK: free_top <= cur;
          OP_BRIBE: head_id <= cur;
          default: ;
        endcase
      end
      if (state == S_DONE) res_pending <= 1'b1;
      if (res_pending && (!out_valid || !out_stall)) res_pending <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_pending && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_pending && (!out_valid || !out_stall)) begin
      out_data.out_id     <= (res_status == ST_OK) ? 8'(cur) : 8'd0;
      out_data.status     <= res_status;
      out_data.length_now <= 9'(entry_count);
    end
  end

endmodule

// ===== src/isq_checker.sv =====
module isq_checker import isq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input isq_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input isq_out_t out_data
);
  `include "indexed_service_queue_unit_defines.svh"

  `ISQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `ISQ_ASSERT_IMPL(a_status_code, out_valid, out_data.status == ST_OK || out_data.status == ST_ABSENT || out_data.status == ST_FULL, "bad status code")
  `ISQ_ASSERT_IMPL(a_id_zero, out_valid && out_data.status != ST_OK, out_data.out_id == 8'd0, "id not zero on error")
  `ISQ_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second item taken while busy")
endmodule

bind indexed_service_queue_unit isq_checker u_isq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== dv/indexed_service_queue_unit_tb.sv =====
module indexed_service_queue_unit_tb;
  import isq_pkg::*;

  localparam int NIDS = 256;
  localparam int NIL = NIDS;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  isq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  isq_out_t out_data;

  indexed_service_queue_unit #(.ID_COUNT(NIDS)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the queue, the link tables and the free stack
  int succ [NIDS];
  int pred [NIDS];
  bit in_line [NIDS];
  int front_id, back_id, free_head, fresh_count, line_len;

  isq_out_t due_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;
  bit calm = 1'b0;

  function automatic void detach(int id);
    int p, n;
    p = pred[id];
    n = succ[id];
    if (p < NIL) succ[p] = n; else front_id = n;
    if (n < NIL) pred[n] = p; else back_id = p;
  endfunction

  function automatic void retire(int id);
    detach(id);
    in_line[id] = 1'b0;
    succ[id] = free_head;
    free_head = id;
    line_len--;
  endfunction

  function automatic void enqueue(int id);
    pred[id] = back_id;
    succ[id] = NIL;
    if (back_id < NIL) succ[back_id] = id; else front_id = id;
    back_id = id;
    in_line[id] = 1'b1;
    line_len++;
  endfunction

  function automatic isq_out_t serve(isq_in_t it);
    isq_out_t r;
    int id, bid;
    logic [1:0] st;
    id = 0;
    st = ST_OK;
    bid = int'(it.buzzer_id);
    case (it.operation)
      OP_GIVE: begin
        if (free_head < NIL) begin
          id = free_head;
          free_head = succ[id];
          enqueue(id);
        end else if (fresh_count < NIDS) begin
          id = fresh_count;
          fresh_count++;
          enqueue(id);
        end else st = ST_FULL;
      end
      OP_SEAT: begin
        if (front_id < NIL) begin
          id = front_id;
          retire(id);
        end else st = ST_ABSENT;
      end
      default: begin
        if (!in_line[bid]) st = ST_ABSENT;
        else begin
          id = bid;
          if (it.operation == OP_KICK) retire(id);
          else if (front_id != id) begin
            detach(id);
            pred[id] = NIL;
            succ[id] = front_id;
            if (front_id < NIL) pred[front_id] = id; else back_id = id;
            front_id = id;
          end
        end
      end
    endcase
    r.out_id = (st == ST_OK) ? id[7:0] : 8'd0;
    r.status = st;
    r.length_now = line_len[8:0];
    return r;
  endfunction

  // directed rows: fixed expectation only where obvious
  typedef struct {
    logic [1:0] op;
    logic [7:0] bid;
    bit known;
    logic [7:0] xid;
    logic [1:0] xst;
    logic [8:0] xlen;
  } row_t;

  row_t rows [] = '{
    '{OP_SEAT, 8'd0, 1, 8'd0, ST_ABSENT, 9'd0},
    '{OP_KICK, 8'd0, 1, 8'd0, ST_ABSENT, 9'd0},
    '{OP_BRIBE, 8'd255, 1, 8'd0, ST_ABSENT, 9'd0},
    '{OP_GIVE, 8'd255, 1, 8'd0, ST_OK, 9'd1},
    '{OP_GIVE, 8'd0, 1, 8'd1, ST_OK, 9'd2},
    '{OP_GIVE, 8'd0, 1, 8'd2, ST_OK, 9'd3},
    '{OP_GIVE, 8'd0, 1, 8'd3, ST_OK, 9'd4},
    '{OP_BRIBE, 8'd0, 1, 8'd0, ST_OK, 9'd4},
    '{OP_BRIBE, 8'd2, 0, 0, 0, 0},
    '{OP_BRIBE, 8'd3, 0, 0, 0, 0},
    '{OP_KICK, 8'd1, 0, 0, 0, 0},
    '{OP_KICK, 8'd3, 0, 0, 0, 0},
    '{OP_KICK, 8'd1, 1, 8'd0, ST_ABSENT, 9'd2},
    '{OP_GIVE, 8'd0, 0, 0, 0, 0},
    '{OP_GIVE, 8'd0, 0, 0, 0, 0},
    '{OP_GIVE, 8'd0, 0, 0, 0, 0},
    '{OP_SEAT, 8'd170, 0, 0, 0, 0},
    '{OP_KICK, 8'd255, 1, 8'd0, ST_ABSENT, 9'd4},
    '{OP_BRIBE, 8'd4, 0, 0, 0, 0},
    '{OP_SEAT, 8'd0, 0, 0, 0, 0},
    '{OP_SEAT, 8'd0, 0, 0, 0, 0},
    '{OP_SEAT, 8'd0, 0, 0, 0, 0},
    '{OP_SEAT, 8'd0, 0, 0, 0, 0},
    '{OP_SEAT, 8'd0, 1, 8'd0, ST_ABSENT, 9'd0}
  };

  // in_valid stays high after an accept until the next item or an idle cycle
  task automatic offer(isq_in_t it, bit known, isq_out_t fixed);
    isq_out_t want;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    want = serve(it);
    if (known && want !== fixed) begin
      $display("%0t predictor disagrees on row: expected %h actual %h", $time, fixed, want);
      errors++;
    end
    due_q.push_back(known ? fixed : want);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // random op mix leaning on queued ids
  function automatic isq_in_t pick(int bias);
    isq_in_t it;
    int k;
    k = $urandom_range(99);
    it.buzzer_id = 8'($urandom);
    if (k < bias) it.operation = OP_GIVE;
    else if (k < bias + 15) it.operation = OP_SEAT;
    else it.operation = (k & 1) ? OP_KICK : OP_BRIBE;
    if (it.operation inside {OP_KICK, OP_BRIBE} && line_len > 0 && $urandom_range(9) < 8)
      begin
        int j, steps;
        j = front_id;
        steps = $urandom_range(line_len - 1);
        repeat (steps) j = succ[j];
        it.buzzer_id = j[7:0];
      end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    isq_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = due_q.pop_front();
        if (out_data.out_id !== want.out_id) begin
          $display("%0t out_id: expected %0d actual %0d", $time, want.out_id, out_data.out_id);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.length_now !== want.length_now) begin
          $display("%0t length_now: expected %0d actual %0d", $time, want.length_now,
                   out_data.length_now);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("indexed_service_queue_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    isq_in_t it;
    isq_out_t fx;
    for (int i = 0; i < NIDS; i++) begin
      succ[i] = 0;
      pred[i] = 0;
      in_line[i] = 1'b0;
    end
    front_id = NIL;
    back_id = NIL;
    free_head = NIL;
    fresh_count = 0;
    line_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      it.operation = rows[i].op;
      it.buzzer_id = rows[i].bid;
      fx.out_id = rows[i].xid;
      fx.status = rows[i].xst;
      fx.length_now = rows[i].xlen;
      offer(it, rows[i].known, fx);
    end
    // sender pause until all results are in
    drain();

    // grow the queue with mostly gives, then continue with a mixed op stream
    for (int i = 0; i < 300; i++) offer(pick(i < 260 ? 90 : 60), 0, '0);

    // receiver holds off for a long stretch while items keep coming
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 40; i++) offer(pick(40), 0, '0);
    join
    drain();

    // churn with no idling
    calm = 1'b1;
    for (int i = 0; i < 300; i++) offer(pick(45), 0, '0);
    calm = 1'b0;

    // shrink the queue with mostly removals, then mixed random traffic
    for (int i = 0; i < 300; i++) offer(pick(10), 0, '0);
    for (int i = 0; i < 900; i++) offer(pick((i / 150) % 2 ? 60 : 35), 0, '0);

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("indexed_service_queue_unit_tb: PASS");
    else $display("indexed_service_queue_unit_tb: FAIL");
    $finish;
  end

endmodule
